### design/tspat_pkg.sv
// Shared types and constants for the transport-stream PAT section parser.
`timescale 1ns / 1ps

package tspat_pkg;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_SKIP  = 4'd1,
        PH_TID   = 4'd2,
        PH_FLAGS = 4'd3,
        PH_LENLO = 4'd4,
        PH_TSHI  = 4'd5,
        PH_TSLO  = 4'd6,
        PH_VER   = 4'd7,
        PH_SEC   = 4'd8,
        PH_LAST  = 4'd9,
        PH_ENTRY = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TABLE_ID  = 3'd1,
        ST_SSI_CLEAR = 3'd2,
        ST_PRIV_SET  = 3'd3,
        ST_RESERVED  = 3'd4,
        ST_LEN_BITS  = 3'd5,
        ST_MULTISEC  = 3'd6,
        ST_SHORT     = 3'd7
    } status_t;

    localparam logic [7:0] SYNTAX_MASK   = 8'h80;
    localparam logic [7:0] PRIVATE_MASK  = 8'h40;
    localparam logic [7:0] RESERVED_MASK = 8'h30;
    localparam logic [7:0] LENRSV_MASK   = 8'h0C;
    localparam logic [7:0] PIDHI_MASK    = 8'h1F;
    localparam logic [7:0] LENHI_MASK    = 8'h03;
    // CRC (4) plus the header bytes after the length (5)
    localparam logic [9:0] MIN_SEC_LEN   = 10'd9;

    // One result item, as produced by the parser core
    typedef struct packed {
        logic        pid_valid;
        logic [12:0] pmt_pid;
        logic        done_res;
        status_t     status;
        logic [7:0]  program_count;
        logic [15:0] stream_id;
        logic        extra_bytes;
    } result_t;

endpackage

### design/tspat_core.sv
// Parser state and per-byte step logic for one PAT section byte.
`timescale 1ns / 1ps

module tspat_core
    import tspat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  skip_left_reg, skip_left_next;
    logic [9:0]  bytes_left_reg, bytes_left_next;
    logic [1:0]  entry_pos_reg, entry_pos_next;
    logic [4:0]  pid_high_reg, pid_high_next;
    logic [15:0] stream_id_reg, stream_id_next;
    logic [7:0]  entry_count_reg, entry_count_next;
    logic [1:0]  length_high_reg, length_high_next;

    logic [9:0]  sec_len;
    logic [9:0]  bl_dec;
    logic [7:0]  skip_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            skip_left_reg   <= '0;
            bytes_left_reg  <= '0;
            entry_pos_reg   <= '0;
            pid_high_reg    <= '0;
            stream_id_reg   <= '0;
            entry_count_reg <= '0;
            length_high_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            skip_left_reg   <= skip_left_next;
            bytes_left_reg  <= bytes_left_next;
            entry_pos_reg   <= entry_pos_next;
            pid_high_reg    <= pid_high_next;
            stream_id_reg   <= stream_id_next;
            entry_count_reg <= entry_count_next;
            length_high_reg <= length_high_next;
        end
    end

    assign sec_len  = {length_high_reg, data_byte};
    assign bl_dec   = bytes_left_reg - 10'd1;
    assign skip_dec = skip_left_reg - 8'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        skip_left_next   = skip_left_reg;
        bytes_left_next  = bytes_left_reg;
        entry_pos_next   = entry_pos_reg;
        pid_high_next    = pid_high_reg;
        stream_id_next   = stream_id_reg;
        entry_count_next = entry_count_reg;
        length_high_next = length_high_reg;
        res_valid        = 1'b0;
        res              = '0;
        res.status       = ST_OK;

        if (first_byte)
        begin
            skip_left_next   = data_byte;
            bytes_left_next  = '0;
            entry_pos_next   = '0;
            pid_high_next    = '0;
            stream_id_next   = '0;
            entry_count_next = '0;
            length_high_next = '0;
            phase_next       = (data_byte == 8'd0) ? PH_TID : PH_SKIP;
        end
        else
        begin
            case (phase_reg)
                PH_SKIP:
                begin
                    skip_left_next = skip_dec;
                    if (skip_dec == 8'd0)
                        phase_next = PH_TID;
                end
                PH_TID:
                begin
                    if (data_byte != 8'd0)
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_TABLE_ID;
                    end
                    else
                        phase_next = PH_FLAGS;
                end
                PH_FLAGS:
                begin
                    res.done_res = 1'b1;
                    if ((data_byte & SYNTAX_MASK) == 8'd0)
                        res.status = ST_SSI_CLEAR;
                    else if ((data_byte & PRIVATE_MASK) != 8'd0)
                        res.status = ST_PRIV_SET;
                    else if ((data_byte & RESERVED_MASK) != RESERVED_MASK)
                        res.status = ST_RESERVED;
                    else if ((data_byte & LENRSV_MASK) != 8'd0)
                        res.status = ST_LEN_BITS;
                    else
                    begin
                        res.done_res     = 1'b0;
                        length_high_next = data_byte[1:0] & LENHI_MASK[1:0];
                        phase_next       = PH_LENLO;
                    end
                end
                PH_LENLO:
                begin
                    if (sec_len < MIN_SEC_LEN)
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_SHORT;
                    end
                    else
                    begin
                        bytes_left_next = sec_len - MIN_SEC_LEN;
                        phase_next      = PH_TSHI;
                    end
                end
                PH_TSHI:
                begin
                    stream_id_next = {data_byte, 8'd0};
                    phase_next     = PH_TSLO;
                end
                PH_TSLO:
                begin
                    stream_id_next = {stream_id_reg[15:8], data_byte};
                    phase_next     = PH_VER;
                end
                PH_VER:
                    phase_next = PH_SEC;
                PH_SEC:
                begin
                    if (data_byte != 8'd0)
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_MULTISEC;
                    end
                    else
                        phase_next = PH_LAST;
                end
                PH_LAST:
                begin
                    if (data_byte != 8'd0)
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_MULTISEC;
                    end
                    else if (bytes_left_reg == 10'd0)
                        res.done_res = 1'b1;
                    else
                    begin
                        entry_pos_next = '0;
                        phase_next     = PH_ENTRY;
                    end
                end
                PH_ENTRY:
                begin
                    if (entry_pos_reg == 2'd2)
                        pid_high_next = data_byte[4:0] & PIDHI_MASK[4:0];
                    if (entry_pos_reg == 2'd3)
                    begin
                        res.pid_valid    = 1'b1;
                        res.pmt_pid      = {pid_high_reg, data_byte};
                        entry_count_next = entry_count_reg + 8'd1;
                    end
                    entry_pos_next  = entry_pos_reg + 2'd1;
                    bytes_left_next = bl_dec;
                    if (bl_dec == 10'd0)
                    begin
                        res.done_res    = 1'b1;
                        res.extra_bytes = (entry_pos_reg != 2'd3);
                    end
                end
                default:
                    ;
            endcase

            if (res.done_res)
            begin
                phase_next        = PH_IDLE;
                res.program_count = entry_count_next;
                res.stream_id     = stream_id_reg;
            end
        end

        res_valid = res.pid_valid | res.done_res;
    end

endmodule

### design/ts_pat_section_parser_unit.sv
// Top level of the transport-stream PAT section parser.
`timescale 1ns / 1ps

// Usage
//   Input stream: one section byte per request. s_axis_tdata carries the byte,
//   s_axis_tuser flags the pointer-field byte that opens a new section.
//   Output stream: at most one result per input byte, only when a program
//   entry completes or the section finishes or fails. m_axis_tlast is the
//   done flag; m_axis_tdata carries PID, status, count, stream id, extra flag.
// Path: an accepted byte loads the input register; the parser steps on it and
//   its result request loads the result register once that register is free.
//   Bytes that yield no result simply update parser state.
// Throughput: one byte per cycle while m_axis_tready is high; the per-byte
//   step is a small field check and a 10-bit decrement between two registers.
// Stall: when the receiver holds m_axis_tready low, the result register holds
//   its request, the input register fills and then s_axis_tready drops; no
//   byte is lost or reordered.
// Reset: rst_n clears both stages and puts the parser in idle, waiting for a
//   flagged first byte. Unflagged bytes while idle are accepted and dropped.

module ts_pat_section_parser_unit
    import tspat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] first_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] pid_valid, [13:1] pmt_pid, [16:14] status, [24:17] program_count,
    // [40:25] stream_id, [41] extra_bytes, [47:42] zero
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast    // done_res
);

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_first_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;

    logic       advance;
    logic       core_valid;
    result_t    core_res;

    // Step the parser whenever a byte is waiting and the result slot frees up
    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
        end
    end

    tspat_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .data_byte  (in_data_reg),
        .first_byte (in_first_reg),
        .res_valid  (core_valid),
        .res        (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= core_valid;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_valid)
            out_res_reg <= core_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_res_reg.done_res;
    assign m_axis_tdata  = {6'd0,
                            out_res_reg.extra_bytes,
                            out_res_reg.stream_id,
                            out_res_reg.program_count,
                            out_res_reg.status,
                            out_res_reg.pmt_pid,
                            out_res_reg.pid_valid};

endmodule

### design/tspat_checker.sv
// Port-level checks for the PAT section parser, bound to the top level.
`timescale 1ns / 1ps

module tspat_checker
    import tspat_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result request changed while stalled");

    // Every result carries an entry or a finish
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] || m_axis_tlast))
        else $error("empty result");

    // PID is zero unless an entry completed
    a_pid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[13:1] == 13'd0))
        else $error("pid set without entry");

    // Status fields are zero unless the section finished
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            (m_axis_tdata[47:14] == 34'd0))
        else $error("status fields set without finish");

    // Extra-bytes flag only on a successful finish
    a_extra_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[41] |->
            (m_axis_tdata[16:14] == ST_OK))
        else $error("extra bytes flagged on error");

endmodule

bind ts_pat_section_parser_unit tspat_checker u_tspat_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### dv/ts_pat_section_parser_unit_tb.sv
// Self-checking testbench for the PAT section parser: byte stream in, PID and status out.
`timescale 1ns / 1ps

module ts_pat_section_parser_unit_tb;
    import tspat_pkg::*;

    localparam int CLK_HALF_NS   = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int TOTAL_BYTES   = 1050;
    localparam int IDLE_PCT      = 26;
    localparam int CALM_FROM     = 700;     // accepted-byte window with no idling
    localparam int CALM_TO       = 900;
    localparam int HOLD_AT       = 400;     // accepted bytes before the long receiver hold
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_CAP     = 40;

    // Ways a generated section header is broken on purpose
    typedef enum int {
        FLT_NONE,
        FLT_TID,
        FLT_SSI,
        FLT_PRIV,
        FLT_RSV,
        FLT_LENBITS,
        FLT_SECNUM,
        FLT_LASTNUM
    } fault_t;

    // One pending input request; drain makes the sender wait for all results first
    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       drain;
    } byte_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;    // [0] first_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] pid_valid, [13:1] pmt_pid, [16:14] status, [24:17] program_count,
    // [40:25] stream_id, [41] extra_bytes, [47:42] zero
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;           // done_res

    ts_pat_section_parser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    byte_req_t   byte_q[$];          // section bytes still to be offered
    result_t     pat_results_q[$];   // predicted parser results, oldest first

    // Shadow parser state
    phase_t      ph = PH_IDLE;
    logic [7:0]  skip_cnt = '0;
    logic [9:0]  remain = '0;
    logic [1:0]  epos = '0;
    logic [4:0]  pid_hi = '0;
    logic [15:0] ts_id = '0;
    logic [7:0]  n_prog = '0;
    logic [1:0]  len_hi = '0;

    int          err_cnt = 0;
    int          acc_cnt = 0;
    int          res_cnt = 0;
    int          pid_cnt = 0;
    int          sec_cnt = 0;
    int          cycle_cnt = 0;
    logic [7:0]  status_seen = '0;
    logic        took_last = 1'b0;
    logic        calm;

    assign calm = (acc_cnt >= CALM_FROM) && (acc_cnt < CALM_TO);

    // Advance the shadow parser by one accepted byte and queue any result it yields
    task automatic parse_byte(input logic [7:0] b, input logic first);
        result_t    r;
        logic [9:0] len;
        logic       fin;
        logic       extra;
        status_t    st;
        r     = '0;
        fin   = 1'b0;
        extra = 1'b0;
        st    = ST_OK;
        len   = {len_hi, b};
        if (first)
        begin
            // pointer field: always restarts, an open section is dropped silently
            skip_cnt = b;
            remain   = '0;
            epos     = '0;
            pid_hi   = '0;
            ts_id    = '0;
            n_prog   = '0;
            len_hi   = '0;
            ph       = (b == 8'd0) ? PH_TID : PH_SKIP;
        end
        else
        begin
            case (ph)
                PH_SKIP:
                begin
                    skip_cnt = skip_cnt - 8'd1;
                    if (skip_cnt == 8'd0)
                        ph = PH_TID;
                end
                PH_TID:
                begin
                    if (b != 8'd0)
                    begin
                        fin = 1'b1;
                        st  = ST_TABLE_ID;
                    end
                    else
                        ph = PH_FLAGS;
                end
                PH_FLAGS:
                begin
                    fin = 1'b1;
                    if ((b & SYNTAX_MASK) == 8'd0)
                        st = ST_SSI_CLEAR;
                    else if ((b & PRIVATE_MASK) != 8'd0)
                        st = ST_PRIV_SET;
                    else if ((b & RESERVED_MASK) != RESERVED_MASK)
                        st = ST_RESERVED;
                    else if ((b & LENRSV_MASK) != 8'd0)
                        st = ST_LEN_BITS;
                    else
                    begin
                        fin    = 1'b0;
                        len_hi = b[1:0];
                        ph     = PH_LENLO;
                    end
                end
                PH_LENLO:
                begin
                    if (len < MIN_SEC_LEN)
                    begin
                        fin = 1'b1;
                        st  = ST_SHORT;
                    end
                    else
                    begin
                        remain = len - MIN_SEC_LEN;
                        ph     = PH_TSHI;
                    end
                end
                PH_TSHI:
                begin
                    ts_id = {b, 8'h00};
                    ph    = PH_TSLO;
                end
                PH_TSLO:
                begin
                    ts_id = {ts_id[15:8], b};
                    ph    = PH_VER;
                end
                PH_VER:
                    ph = PH_SEC;
                PH_SEC:
                begin
                    if (b != 8'd0)
                    begin
                        fin = 1'b1;
                        st  = ST_MULTISEC;
                    end
                    else
                        ph = PH_LAST;
                end
                PH_LAST:
                begin
                    if (b != 8'd0)
                    begin
                        fin = 1'b1;
                        st  = ST_MULTISEC;
                    end
                    else if (remain == 10'd0)
                        fin = 1'b1;     // empty program loop
                    else
                    begin
                        epos = '0;
                        ph   = PH_ENTRY;
                    end
                end
                PH_ENTRY:
                begin
                    if (epos == 2'd2)
                        pid_hi = b[4:0];
                    if (epos == 2'd3)
                    begin
                        r.pid_valid = 1'b1;
                        r.pmt_pid   = {pid_hi, b};
                        n_prog      = n_prog + 8'd1;
                    end
                    epos   = epos + 2'd1;
                    remain = remain - 10'd1;
                    if (remain == 10'd0)
                    begin
                        fin   = 1'b1;
                        extra = (epos != 2'd0);
                    end
                end
                default: ;  // idle: stray bytes are dropped
            endcase
        end
        if (fin)
        begin
            r.done_res      = 1'b1;
            r.status        = st;
            r.program_count = n_prog;
            r.stream_id     = ts_id;
            r.extra_bytes   = extra;
            ph              = PH_IDLE;
        end
        if (r.pid_valid || r.done_res)
            pat_results_q = {pat_results_q, r};
    endtask

    task automatic push_req(input logic [7:0] data, input logic first, input logic drain);
        byte_req_t q;
        q.data  = data;
        q.first = first;
        q.drain = drain;
        byte_q  = {byte_q, q};
    endtask

    // Queue one section: pointer field, filler, header, body, CRC; optionally
    // broken in one header field or cut short so the next start drops it.
    task automatic emit_section(input int ptr, input int sec_len, input fault_t fault,
                                input int cut, input logic drain);
        logic [7:0] sec[$];
        logic [9:0] sl;
        logic [7:0] tid;
        logic [7:0] flags;
        logic [7:0] secn;
        logic [7:0] lastn;
        logic [15:0] tsv;
        int          n_body;
        sl    = 10'(sec_len);
        tid   = 8'h00;
        flags = {1'b1, 1'b0, 2'b11, 2'b00, sl[9:8]};
        secn  = 8'h00;
        lastn = 8'h00;
        tsv   = 16'($urandom_range(0, 65535));
        case (fault)
            FLT_TID:     tid = 8'($urandom_range(1, 255));
            FLT_SSI:     flags = {1'b0, 7'($urandom_range(0, 127))};
            FLT_PRIV:    flags = {2'b11, 6'($urandom_range(0, 63))};
            FLT_RSV:     flags[5:4] = 2'($urandom_range(0, 2));
            FLT_LENBITS: flags[3:2] = 2'($urandom_range(1, 3));
            FLT_SECNUM:  secn = 8'($urandom_range(1, 255));
            FLT_LASTNUM: lastn = 8'($urandom_range(1, 255));
            default: ;
        endcase
        for (int i = 0; i < ptr; i++)
            sec = {sec, 8'($urandom_range(0, 255))};
        sec = {sec, tid};
        sec = {sec, flags};
        sec = {sec, sl[7:0]};
        sec = {sec, tsv[15:8]};
        sec = {sec, tsv[7:0]};
        sec = {sec, 8'($urandom_range(0, 255))};  // version / current-next
        sec = {sec, secn};
        sec = {sec, lastn};
        n_body = (sec_len >= 9) ? sec_len - 9 + 4 : 4;   // program loop plus CRC
        for (int i = 0; i < n_body; i++)
            sec = {sec, 8'($urandom_range(0, 255))};
        if (cut > 0 && cut < sec.size())
            sec = sec[0:cut - 1];
        push_req(8'(ptr), 1'b1, drain);
        foreach (sec[i])
            push_req(sec[i], 1'b0, 1'b0);
        sec_cnt++;
    endtask

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (err_cnt < PRINT_CAP)
            $display("[%0t] mismatch in result %0d, %s: got 0x%0h, expected 0x%0h",
                     $realtime, res_cnt, field, got, want);
        err_cnt++;
    endtask

    // Input side: record each accepted request and run the shadow parser on it.
    always @(posedge clk)
    begin
        took_last <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
        begin
            parse_byte(s_axis_tdata, s_axis_tuser);
            void'(byte_q.pop_front());
            acc_cnt++;
        end
    end

    // Driver: a request is held until accepted; between requests the sender
    // idles at random, except in the calm window and when a drain mark asks it
    // to wait for every outstanding result.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !took_last)
                ;   // request still pending, keep it steady
            else if (byte_q.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (byte_q[0].drain && pat_results_q.size() != 0)
                s_axis_tvalid <= 1'b0;
            else if (!calm && $urandom_range(0, 99) < IDLE_PCT)
                s_axis_tvalid <= 1'b0;
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= byte_q[0].data;
                s_axis_tuser  <= byte_q[0].first;
            end
        end
    end

    // Receiver backpressure: random stalls plus one long hold so the parser's
    // stages fill and s_axis_tready drops while the sender keeps offering.
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && acc_cnt >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (calm)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Output monitor: every accepted result must match the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pat_results_q.size() == 0)
                flag_mismatch("unexpected result", 32'(m_axis_tdata[24:0]), 32'd0);
            else
            begin
                want = pat_results_q.pop_front();
                if (m_axis_tdata[0] !== want.pid_valid)
                    flag_mismatch("pid_valid", 32'(m_axis_tdata[0]), 32'(want.pid_valid));
                if (m_axis_tdata[13:1] !== want.pmt_pid)
                    flag_mismatch("pmt_pid", 32'(m_axis_tdata[13:1]), 32'(want.pmt_pid));
                if (m_axis_tlast !== want.done_res)
                    flag_mismatch("done_res", 32'(m_axis_tlast), 32'(want.done_res));
                if (m_axis_tdata[16:14] !== want.status)
                    flag_mismatch("status", 32'(m_axis_tdata[16:14]), 32'(want.status));
                if (m_axis_tdata[24:17] !== want.program_count)
                    flag_mismatch("program_count", 32'(m_axis_tdata[24:17]),
                                  32'(want.program_count));
                if (m_axis_tdata[40:25] !== want.stream_id)
                    flag_mismatch("stream_id", 32'(m_axis_tdata[40:25]),
                                  32'(want.stream_id));
                if (m_axis_tdata[41] !== want.extra_bytes)
                    flag_mismatch("extra_bytes", 32'(m_axis_tdata[41]),
                                  32'(want.extra_bytes));
                if (m_axis_tdata[47:42] !== 6'd0)
                    flag_mismatch("pad bits", 32'(m_axis_tdata[47:42]), 32'd0);
                if (want.pid_valid)
                    pid_cnt++;
                if (want.done_res)
                    status_seen[want.status] = 1'b1;
            end
            res_cnt++;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d requests still queued",
                     cycle_cnt, byte_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int     pick;
        int     lenr;
        int     ptr;
        int     sec_len;
        int     cut;
        int     n_noise;
        fault_t fault;

        // Directed: stray idle byte, table id error, syntax bit clear,
        // short length, then one entry (max PID) finishing on the same byte.
        push_req(8'hFF, 1'b0, 1'b0);
        push_req(8'h00, 1'b1, 1'b0); push_req(8'hFF, 1'b0, 1'b0);
        push_req(8'h00, 1'b1, 1'b0); push_req(8'h00, 1'b0, 1'b0);
        push_req(8'h7F, 1'b0, 1'b0);
        push_req(8'h00, 1'b1, 1'b0); push_req(8'h00, 1'b0, 1'b0);
        push_req(8'hB0, 1'b0, 1'b0); push_req(8'h08, 1'b0, 1'b0);
        push_req(8'h00, 1'b1, 1'b0); push_req(8'h00, 1'b0, 1'b0);
        push_req(8'hB0, 1'b0, 1'b0); push_req(8'h0D, 1'b0, 1'b0);
        push_req(8'hFF, 1'b0, 1'b0); push_req(8'hFF, 1'b0, 1'b0);
        push_req(8'hC1, 1'b0, 1'b0); push_req(8'h00, 1'b0, 1'b0);
        push_req(8'h00, 1'b0, 1'b0); push_req(8'hE0, 1'b0, 1'b0);
        push_req(8'h00, 1'b0, 1'b0); push_req(8'hFF, 1'b0, 1'b0);
        push_req(8'hFF, 1'b0, 1'b0);
        sec_cnt = 4;

        // Random: mostly well-formed sections with random content, some with a
        // broken header field, some cut short by a restart, plus noise bytes.
        while (byte_q.size() < TOTAL_BYTES)
        begin
            pick    = $urandom_range(0, 99);
            lenr    = $urandom_range(0, 99);
            ptr     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
            if (lenr < 55)
                sec_len = 9 + 4 * $urandom_range(0, 8);
            else if (lenr < 85)
                sec_len = $urandom_range(9, 60);
            else
                sec_len = $urandom_range(0, 8);
            fault = (pick < 20) ? fault_t'($urandom_range(1, 7)) : FLT_NONE;
            cut   = (pick >= 20 && pick < 30) ? $urandom_range(2, 10) : 0;
            if (sec_cnt == 5)
            begin
                // largest pointer field
                ptr     = 255;
                sec_len = 13;
                fault   = FLT_NONE;
                cut     = 0;
            end
            else if (sec_cnt == 7)
            begin
                // length above 255: 64 entries and three leftover bytes
                ptr     = 0;
                sec_len = 268;
                fault   = FLT_NONE;
                cut     = 0;
            end
            emit_section(ptr, sec_len, fault, cut, (sec_cnt % 6) == 5);
            if (pick >= 90)
            begin
                n_noise = $urandom_range(1, 6);
                for (int i = 0; i < n_noise; i++)
                    push_req(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0), 1'b0);
            end
        end

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0 || pat_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d sections over %0d accepted bytes; checked %0d results, %0d PIDs",
                 sec_cnt, acc_cnt, res_cnt, pid_cnt);
        $display("Status codes seen (bit per code, code 0 rightmost): %08b", status_seen);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
